// File: rtl/core/hfir_iq_pkg.sv
// ----------------------------------------------------------------------------
// hfir_iq_pkg
// Shared widths and the odd-index tap table of the Hilbert converter.
// ----------------------------------------------------------------------------
package hfir_iq_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CoefBits   = 18;
  localparam int unsigned CoefFrac   = CoefBits - 1;
  localparam int unsigned OutBits    = SampleBits + 2;
  localparam int unsigned TapTable   = 50;
  localparam int unsigned ProdBits   = SampleBits + CoefBits;
  localparam int unsigned SumBits    = ProdBits + $clog2(TapTable);
  localparam int unsigned GroupSize  = 8;
  localparam int unsigned MaxGroups  = (TapTable + GroupSize - 1) / GroupSize;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [CoefBits-1:0]   coef_t;
  typedef logic signed [ProdBits-1:0]   prod_t;
  typedef logic signed [SumBits-1:0]    sum_t;
  typedef logic signed [OutBits-1:0]    out_t;

  // odd taps 1..99 of the 101-tap filter, Q1.17
  localparam coef_t OddTaps [TapTable] = '{
    -18'sd1703,  -18'sd1775,  -18'sd1854,  -18'sd1941,  -18'sd2035,
    -18'sd2140,  -18'sd2255,  -18'sd2384,  -18'sd2529,  -18'sd2692,
    -18'sd2877,  -18'sd3090,  -18'sd3338,  -18'sd3628,  -18'sd3973,
    -18'sd4392,  -18'sd4908,  -18'sd5563,  -18'sd6419,  -18'sd7586,
    -18'sd9271,  -18'sd11920, -18'sd16689, -18'sd27814, -18'sd83443,
    18'sd83443,  18'sd27814,  18'sd16689,  18'sd11920,  18'sd9271,
    18'sd7586,   18'sd6419,   18'sd5563,   18'sd4908,   18'sd4392,
    18'sd3973,   18'sd3628,   18'sd3338,   18'sd3090,   18'sd2877,
    18'sd2692,   18'sd2529,   18'sd2384,   18'sd2255,   18'sd2140,
    18'sd2035,   18'sd1941,   18'sd1854,   18'sd1775,   18'sd1703
  };

endpackage

// File: rtl/core/hilbert_fir_iq_converter.sv
// ----------------------------------------------------------------------------
// hilbert_fir_iq_converter
// Real-to-IQ conversion of a two-sample-per-clock stream by a Hilbert FIR.
// ----------------------------------------------------------------------------
// Takes one pair of real samples per clock while s_axis_tready is high and
// returns one complex sample per request, mixed to fs/4 by an alternating
// +2/-2 factor. The block sustains one request per cycle while m_axis_tready
// does not stall the output; a request passes four register stages (tap
// products, group sums, total, scale and saturate). The delay line and the
// sign start from zero and +2 after reset.
module hilbert_fir_iq_converter
  import hfir_iq_pkg::*;
#(
  parameter int unsigned FILTER_TAPS  = 101,
  parameter int unsigned PAIR_DEPTH   = 51,
  parameter int unsigned CENTRE_INDEX = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample_even[15:0], sample_odd[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // real_out[17:0], imag_out[35:18], zero
);

  localparam int unsigned HalfTaps = (FILTER_TAPS - 1) / 2;
  localparam int unsigned TapsA    = (HalfTaps > TapTable) ? TapTable : HalfTaps;
  localparam int unsigned NumTaps  = (TapsA > PAIR_DEPTH) ? PAIR_DEPTH : TapsA;
  localparam int unsigned NumGroups = (NumTaps + GroupSize - 1) / GroupSize;
  localparam int unsigned CentreIdx = CENTRE_INDEX % PAIR_DEPTH;

  sample_t sample_even, sample_odd;
  assign sample_even = sample_t'(s_axis_tdata[SampleBits-1:0]);
  assign sample_odd  = sample_t'(s_axis_tdata[2*SampleBits-1:SampleBits]);

  // delay line
  sample_t even_q [PAIR_DEPTH];
  sample_t odd_q  [PAIR_DEPTH];
  sample_t even_sh [PAIR_DEPTH];
  sample_t odd_sh  [PAIR_DEPTH];
  logic    sign_neg_q;

  // pipeline
  logic    en1, en2, en3, en4, accept;
  logic    v1_q, v2_q, v3_q, v4_q;
  prod_t   prod_q [NumTaps];
  prod_t   prod_d [NumTaps];
  sum_t    grp_q  [NumGroups];
  sum_t    grp_d  [NumGroups];
  sum_t    total_q, total_d;
  sample_t re1_q, re2_q, re3_q;
  logic    sg1_q, sg2_q, sg3_q;
  out_t    real_q, imag_q, real_d, imag_d;

  assign en4    = !v4_q || m_axis_tready;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign accept = s_axis_tvalid && en1;
  assign s_axis_tready = en1;

  for (genvar k = 0; k < PAIR_DEPTH; k++) begin : g_shift
    if (k == PAIR_DEPTH - 1) begin : g_top
      assign even_sh[k] = sample_even;
      assign odd_sh[k]  = sample_odd;
    end else begin : g_mid
      assign even_sh[k] = even_q[k+1];
      assign odd_sh[k]  = odd_q[k+1];
    end
  end

  for (genvar i = 0; i < NumTaps; i++) begin : g_tap
    assign prod_d[i] = prod_t'(odd_sh[i]) * prod_t'(OddTaps[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PAIR_DEPTH; k++) begin
        even_q[k] <= '0;
        odd_q[k]  <= '0;
      end
      sign_neg_q <= 1'b0;
    end else if (accept) begin
      for (int k = 0; k < PAIR_DEPTH; k++) begin
        even_q[k] <= even_sh[k];
        odd_q[k]  <= odd_sh[k];
      end
      sign_neg_q <= !sign_neg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < NumTaps) begin
          grp_d[g] = grp_d[g] + sum_t'(prod_q[g * GroupSize + j]);
        end
      end
    end
  end

  always_comb begin
    total_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      total_d = total_d + grp_q[g];
    end
  end

  // negate, floor to sample scale, saturate, apply +/-2
  always_comb begin
    sum_t    neg;
    sum_t    shr;
    sample_t q;
    out_t    q2, r2;
    neg = -total_q;
    shr = neg >>> CoefFrac;
    if (shr > sum_t'(2 ** (SampleBits - 1) - 1)) begin
      q = {1'b0, {(SampleBits-1){1'b1}}};
    end else if (shr < -sum_t'(2 ** (SampleBits - 1))) begin
      q = {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      q = shr[SampleBits-1:0];
    end
    q2 = out_t'(q) <<< 1;
    r2 = out_t'(re3_q) <<< 1;
    imag_d = sg3_q ? -q2 : q2;
    real_d = sg3_q ? -r2 : r2;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && accept) begin
      prod_q <= prod_d;
      re1_q  <= even_sh[CentreIdx];
      sg1_q  <= sign_neg_q;
    end
    if (en2 && v1_q) begin
      grp_q <= grp_d;
      re2_q <= re1_q;
      sg2_q <= sg1_q;
    end
    if (en3 && v2_q) begin
      total_q <= total_d;
      re3_q   <= re2_q;
      sg3_q   <= sg2_q;
    end
    if (en4 && v3_q) begin
      real_q <= real_d;
      imag_q <= imag_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {4'b0, imag_q, real_q};

endmodule
